/* src/etpq_pkg.sv */
package etpq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 32;
  localparam int PID_BITS        = 16;
  localparam int STATUS_BITS     = 4;
  localparam int CMD_BITS        = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

/* src/etpq_cell.sv */
module etpq_cell #(
  parameter int TIME_BITS = etpq_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  etpq_pkg::cell_ctrl_t             ctrl,
  input  logic                             occ,
  input  logic                             left_cond,
  input  logic [TIME_BITS-1:0]             new_time,
  input  logic [etpq_pkg::PID_BITS-1:0]    new_pid,
  input  logic [etpq_pkg::STATUS_BITS-1:0] new_status,
  input  logic [TIME_BITS-1:0]             left_time,
  input  logic [etpq_pkg::PID_BITS-1:0]    left_pid,
  input  logic [etpq_pkg::STATUS_BITS-1:0] left_status,
  input  logic [TIME_BITS-1:0]             right_time,
  input  logic [etpq_pkg::PID_BITS-1:0]    right_pid,
  input  logic [etpq_pkg::STATUS_BITS-1:0] right_status,
  output logic [TIME_BITS-1:0]             time_q,
  output logic [etpq_pkg::PID_BITS-1:0]    pid_q,
  output logic [etpq_pkg::STATUS_BITS-1:0] status_q,
  output logic                             cond
);

  // insertion point lies at or before this cell
  assign cond = !occ || (time_q >= new_time);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (left_cond) begin
        time_q   <= left_time;
        pid_q    <= left_pid;
        status_q <= left_status;
      end else if (cond) begin
        time_q   <= new_time;
        pid_q    <= new_pid;
        status_q <= new_status;
      end
    end else if (ctrl.pop) begin
      time_q   <= right_time;
      pid_q    <= right_pid;
      status_q <= right_status;
    end
  end

endmodule

/* src/event_time_priority_queue_unit.sv */
// channel  dir  signals                      tdata / tuser fields (low bit up)
// s        in   s_tvalid s_tready s_tdata    tdata: event_time, process_id, event_status
//                        s_tuser             tuser: command
// m        out  m_tvalid m_tready m_tdata    tdata: head_valid, head_time, head_pid,
//                                                   head_status, push_dropped,
//                                                   is_empty, entry_count
// One request per cycle while s_tready is high: every cell compares against the pushed
// time and shifts in the same cycle, so a push, pop or peek completes in the cycle it is
// taken. The result register takes a new result in the cycle a waiting one is taken; the
// input stalls only when that register is full and m_tready is low.
// Synchronous reset empties the queue and drops any pending result.
module event_time_priority_queue_unit #(
  parameter int QUEUE_DEPTH = etpq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = etpq_pkg::DEF_TIME_BITS,
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_BITS    = TIME_BITS + etpq_pkg::PID_BITS + etpq_pkg::STATUS_BITS,
  localparam int IN_W       = (IN_BITS + 7) / 8 * 8,
  localparam int OUT_BITS   = 3 + TIME_BITS + etpq_pkg::PID_BITS
                              + etpq_pkg::STATUS_BITS + COUNT_BITS,
  localparam int OUT_W      = (OUT_BITS + 7) / 8 * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // event_time, process_id, event_status
  input  logic [IN_W-1:0]               s_tdata,
  // command
  input  logic [etpq_pkg::CMD_BITS-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // head_valid, head_time, head_pid, head_status, push_dropped, is_empty, entry_count
  output logic [OUT_W-1:0]              m_tdata
);

  localparam int PID_LO = TIME_BITS;
  localparam int ST_LO  = TIME_BITS + etpq_pkg::PID_BITS;

  logic [TIME_BITS-1:0]             in_time;
  logic [etpq_pkg::PID_BITS-1:0]    in_pid;
  logic [etpq_pkg::STATUS_BITS-1:0] in_status;
  etpq_pkg::cmd_t                   cmd;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  nonempty;
  logic                  is_push;
  logic                  is_pop;
  logic                  is_peek;
  etpq_pkg::cell_ctrl_t  ctrl;

  logic [TIME_BITS-1:0]             c_time   [QUEUE_DEPTH];
  logic [etpq_pkg::PID_BITS-1:0]    c_pid    [QUEUE_DEPTH];
  logic [etpq_pkg::STATUS_BITS-1:0] c_status [QUEUE_DEPTH];
  logic                             c_cond   [QUEUE_DEPTH];

  logic                             head_valid;
  logic [TIME_BITS-1:0]             head_time;
  logic [etpq_pkg::PID_BITS-1:0]    head_pid;
  logic [etpq_pkg::STATUS_BITS-1:0] head_status;
  logic                             push_dropped;
  logic                             is_empty;
  logic [COUNT_BITS-1:0]            entry_count;

  assign in_time   = s_tdata[TIME_BITS-1:0];
  assign in_pid    = s_tdata[PID_LO +: etpq_pkg::PID_BITS];
  assign in_status = s_tdata[ST_LO +: etpq_pkg::STATUS_BITS];
  assign cmd       = etpq_pkg::cmd_t'(s_tuser);

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign nonempty = (count != '0);

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    is_peek = 1'b0;
    case (cmd)
      etpq_pkg::CMD_PUSH: is_push = 1'b1;
      etpq_pkg::CMD_POP:  is_pop  = 1'b1;
      etpq_pkg::CMD_PEEK: is_peek = 1'b1;
      default: ;
    endcase
  end

  assign ctrl.push = accept && is_push && !full;
  assign ctrl.pop  = accept && is_pop && nonempty;

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                             occ;
    logic                             l_cond;
    logic [TIME_BITS-1:0]             l_time;
    logic [etpq_pkg::PID_BITS-1:0]    l_pid;
    logic [etpq_pkg::STATUS_BITS-1:0] l_status;
    logic [TIME_BITS-1:0]             r_time;
    logic [etpq_pkg::PID_BITS-1:0]    r_pid;
    logic [etpq_pkg::STATUS_BITS-1:0] r_status;

    assign occ = (COUNT_BITS'(i) < count);

    if (i == 0) begin : g_head
      assign l_cond   = 1'b0;
      assign l_time   = in_time;
      assign l_pid    = in_pid;
      assign l_status = in_status;
    end else begin : g_mid
      assign l_cond   = c_cond[i-1];
      assign l_time   = c_time[i-1];
      assign l_pid    = c_pid[i-1];
      assign l_status = c_status[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_time   = c_time[i];
      assign r_pid    = c_pid[i];
      assign r_status = c_status[i];
    end else begin : g_body
      assign r_time   = c_time[i+1];
      assign r_pid    = c_pid[i+1];
      assign r_status = c_status[i+1];
    end

    etpq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_cond   (l_cond),
      .new_time    (in_time),
      .new_pid     (in_pid),
      .new_status  (in_status),
      .left_time   (l_time),
      .left_pid    (l_pid),
      .left_status (l_status),
      .right_time  (r_time),
      .right_pid   (r_pid),
      .right_status(r_status),
      .time_q      (c_time[i]),
      .pid_q       (c_pid[i]),
      .status_q    (c_status[i]),
      .cond        (c_cond[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_valid   <= (is_pop || is_peek) && nonempty;
      head_time    <= ((is_pop || is_peek) && nonempty) ? c_time[0] : '0;
      head_pid     <= ((is_pop || is_peek) && nonempty) ? c_pid[0] : '0;
      head_status  <= ((is_pop || is_peek) && nonempty) ? c_status[0] : '0;
      push_dropped <= is_push && full;
      is_empty     <= (count_next == '0);
      entry_count  <= count_next;
    end
  end

  assign m_tdata = OUT_W'({entry_count, is_empty, push_dropped, head_status,
                           head_pid, head_time, head_valid});

endmodule

/* bench/event_time_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps

module event_time_priority_queue_unit_tb;

  localparam int DEPTH = etpq_pkg::DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [etpq_pkg::CMD_BITS-1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [etpq_pkg::CMD_BITS-1:0]    cmd;
    logic [31:0]                      ev_time;
    logic [etpq_pkg::PID_BITS-1:0]    pid;
    logic [etpq_pkg::STATUS_BITS-1:0] status;
  } request_t;

  // packed from the top bit of the result down to bit 0
  typedef struct packed {
    logic [4:0]                       entry_count;
    logic                             is_empty;
    logic                             push_dropped;
    logic [etpq_pkg::STATUS_BITS-1:0] head_status;
    logic [etpq_pkg::PID_BITS-1:0]    head_pid;
    logic [31:0]                      head_time;
    logic                             head_valid;
  } outcome_t;

  localparam int OUTCOME_BITS = $bits(outcome_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // event_time, process_id, event_status
  logic [55:0] s_tdata = '0;
  // command
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // head_valid, head_time, head_pid, head_status, push_dropped, is_empty, entry_count
  logic [63:0] m_tdata;

  request_t request_backlog[$];
  request_t on_bus;
  outcome_t expected_heads[$];

  logic [31:0]                      model_times [DEPTH];
  logic [etpq_pkg::PID_BITS-1:0]    model_pids  [DEPTH];
  logic [etpq_pkg::STATUS_BITS-1:0] model_status[DEPTH];
  int                               model_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;

  event_time_priority_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic outcome_t predict_queue_step(input request_t req);
    int pos;
    outcome_t res;
    res = '0;
    case (req.cmd)
      etpq_pkg::CMD_PUSH: begin
        if (model_count == DEPTH) begin
          res.push_dropped = 1'b1;
        end else begin
          pos = model_count;
          for (int i = 0; i < model_count; i++) begin
            if (model_times[i] >= req.ev_time) begin
              pos = i;
              break;
            end
          end
          for (int i = model_count; i > pos; i--) begin
            model_times[i]  = model_times[i-1];
            model_pids[i]   = model_pids[i-1];
            model_status[i] = model_status[i-1];
          end
          model_times[pos]  = req.ev_time;
          model_pids[pos]   = req.pid;
          model_status[pos] = req.status;
          model_count++;
        end
      end
      etpq_pkg::CMD_POP, etpq_pkg::CMD_PEEK: begin
        if (model_count > 0) begin
          res.head_valid  = 1'b1;
          res.head_time   = model_times[0];
          res.head_pid    = model_pids[0];
          res.head_status = model_status[0];
          if (req.cmd == etpq_pkg::CMD_POP) begin
            for (int i = 0; i + 1 < model_count; i++) begin
              model_times[i]  = model_times[i+1];
              model_pids[i]   = model_pids[i+1];
              model_status[i] = model_status[i+1];
            end
            model_count--;
          end
        end
      end
      default: ;
    endcase
    res.is_empty = (model_count == 0);
    res.entry_count = model_count[4:0];
    return res;
  endfunction

  function automatic request_t random_request(input int mode);
    request_t req;
    int roll;
    int push_pct;
    int pop_pct;
    push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 45;
    pop_pct  = (mode == 0) ? 10 : (mode == 1) ? 55 : 35;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) req.cmd = etpq_pkg::CMD_PUSH;
    else if (roll < push_pct + pop_pct) req.cmd = etpq_pkg::CMD_POP;
    else if (roll < 95) req.cmd = etpq_pkg::CMD_PEEK;
    else req.cmd = CMD_NOP;
    roll = $urandom_range(0, 9);
    if (roll < 5) req.ev_time = $urandom_range(0, 31);
    else if (roll < 8) req.ev_time = $urandom;
    else if (roll == 8) req.ev_time = '0;
    else req.ev_time = '1;
    req.pid = etpq_pkg::PID_BITS'($urandom);
    req.status = etpq_pkg::STATUS_BITS'($urandom);
    return req;
  endfunction

  function automatic request_t make_request(input logic [1:0] cmd, input logic [31:0] t,
                                            input logic [15:0] pid, input logic [3:0] st);
    request_t req;
    req.cmd = cmd;
    req.ev_time = t;
    req.pid = pid;
    req.status = st;
    return req;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_heads.push_back(predict_queue_step(on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = request_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, on_bus.status, on_bus.pid, on_bus.ev_time};
          s_tuser <= on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = outcome_t'(m_tdata[OUTCOME_BITS-1:0]);
        if (expected_heads.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: %h", m_tdata);
          end
        end else begin
          want = expected_heads.pop_front();
          if (got.head_valid !== want.head_valid || got.head_time !== want.head_time ||
              got.head_pid !== want.head_pid || got.head_status !== want.head_status ||
              got.push_dropped !== want.push_dropped || got.is_empty !== want.is_empty ||
              got.entry_count !== want.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp valid=%0d time=%h pid=%h st=%h drop=%0d empty=%0d n=%0d",
                       want.head_valid, want.head_time, want.head_pid, want.head_status,
                       want.push_dropped, want.is_empty, want.entry_count);
              $display("          got valid=%0d time=%h pid=%h st=%h drop=%0d empty=%0d n=%0d",
                       got.head_valid, got.head_time, got.head_pid, got.head_status,
                       got.push_dropped, got.is_empty, got.entry_count);
            end
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the result register backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    request_backlog.push_back(make_request(etpq_pkg::CMD_POP,  32'd7, 16'h1234, 4'h3));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PEEK, 32'd9, 16'h4321, 4'hc));
    request_backlog.push_back(make_request(CMD_NOP,  '1, '1, '1));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'd100, 16'd1, 4'h1));
    // equal time goes ahead of the older entry
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'd100, 16'd2, 4'h2));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'd0, 16'h0000, 4'h0));
    // larger than every stored time: append at the tail
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'hffff_ffff, 16'hffff, 4'hf));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'd50, 16'haaaa, 4'ha));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'hffff_ffff, 16'h5555, 4'h5));
    for (int i = 0; i < 10; i++) begin
      request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'(20 + 7 * i),
                                             16'(10 + i), 4'(i)));
    end
    // queue is full now
    request_backlog.push_back(make_request(etpq_pkg::CMD_PUSH, 32'd1, 16'hbeef, 4'h7));
    request_backlog.push_back(make_request(CMD_NOP,  32'd0, 16'd0, 4'h0));
    request_backlog.push_back(make_request(etpq_pkg::CMD_PEEK, 32'd0, 16'd0, 4'h0));
    request_backlog.push_back(make_request(etpq_pkg::CMD_POP,  32'd0, 16'd0, 4'h0));
    while (request_backlog.size() != 0) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      send_idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 31 : 0;
      recv_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 31 : 0;
      if (phase == 0) hold_armed = 1'b1;
      mode = 0;
      for (int i = 0; i < 200; i++) begin
        if (i % 24 == 0) mode = $urandom_range(0, 2);
        request_backlog.push_back(random_request(mode));
      end
      while (request_backlog.size() != 0) @(negedge clk);
    end

    while (request_backlog.size() != 0 || s_tvalid || expected_heads.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_heads.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
